// ===== sv/armt_pkg.sv =====
package armt_pkg;

    localparam int MAX_REGIONS = 16;
    localparam int ADDR_BITS   = 32;
    localparam int IDX_W       = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
    localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int SHIFT_W     = 5;
    localparam int RIGHTS_W    = 3;
    localparam int ACT_W       = 3;

    localparam logic [SHIFT_W-1:0]   PAGE_SHIFT_RST  = 5'd12;
    localparam logic [ADDR_BITS-1:0] USER_MIN_RST    = ADDR_BITS'(32'h0000_1000);
    localparam logic [ADDR_BITS-1:0] USER_MAX_RST    = ADDR_BITS'(32'h7FFF_FFFF);
    localparam logic [ADDR_BITS-1:0] KERNEL_BASE_RST = ADDR_BITS'(32'hC000_0000);

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_MIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USER_MAX    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BASE = 2'd3;

    typedef enum logic [ACT_W-1:0] {
        ACT_CLEAR    = 3'd0,
        ACT_RAW_MAP  = 3'd1,
        ACT_USER_MAP = 3'd2,
        ACT_KERN_MAP = 3'd3,
        ACT_UNMAP    = 3'd4,
        ACT_UNMAP_RG = 3'd5,
        ACT_PROTECT  = 3'd6,
        ACT_LOOKUP   = 3'd7
    } act_t;

    typedef enum logic [1:0] {
        CUT_FULL,
        CUT_HEAD,
        CUT_TAIL,
        CUT_SPLIT
    } cut_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_SCAN,
        RD_LAST
    } rd_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_UPD,
        WR_MOVE,
        WR_SPLIT,
        WR_APPEND
    } wr_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PRECHK,
        ST_READ,
        ST_CHECK,
        ST_REMOVE_RD,
        ST_REMOVE_WR,
        ST_SPLIT_WR,
        ST_APPEND,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] virt;
        logic [ADDR_BITS-1:0] phys;
        logic [ADDR_BITS-1:0] len;
        logic [RIGHTS_W-1:0]  rights;
    } entry_t;

    typedef struct packed {
        logic load_item;
        logic clear_cnt;
        logic idx_zero;
        logic idx_inc;
        rd_t  rd;
        wr_t  wr;
        logic cnt_inc;
        logic cnt_dec;
        logic set_ok;
        logic set_hit;
        logic res_load;
    } cmd_t;

    typedef struct packed {
        act_t act;
        logic pre_ok;
        logic cnt_zero;
        logic full;
        logic last;
        logic match;
        cut_t cut;
        logic out_free;
    } sts_t;

endpackage

// ===== sv/armt_ctrl.sv =====
module armt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  armt_pkg::sts_t sts,
    output armt_pkg::cmd_t cmd,
    output armt_pkg::state_t state
);
    import armt_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   is_map;

    assign is_map = (sts.act == ACT_RAW_MAP) || (sts.act == ACT_USER_MAP)
                 || (sts.act == ACT_KERN_MAP);
    assign state    = state_reg;
    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_PRECHK;
            end
            ST_PRECHK:
            begin
                if (sts.act == ACT_CLEAR || !sts.pre_ok)
                    state_next = ST_DONE;
                else if (sts.cnt_zero)
                    state_next = is_map ? ST_APPEND : ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_READ:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (sts.match)
                begin
                    case (sts.act)
                        ACT_UNMAP:
                            state_next = ST_REMOVE_RD;
                        ACT_UNMAP_RG:
                        begin
                            if (sts.cut == CUT_FULL)
                                state_next = ST_REMOVE_RD;
                            else if (sts.cut == CUT_SPLIT && !sts.full)
                                state_next = ST_SPLIT_WR;
                            else
                                state_next = ST_DONE;
                        end
                        default:
                            state_next = ST_DONE;
                    endcase
                end
                else if (sts.last)
                    state_next = is_map ? ST_APPEND : ST_DONE;
                else
                    state_next = ST_READ;
            end
            ST_REMOVE_RD:
                state_next = ST_REMOVE_WR;
            ST_REMOVE_WR,
            ST_SPLIT_WR,
            ST_APPEND:
                state_next = ST_DONE;
            ST_DONE:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.rd = RD_NONE;
        cmd.wr = WR_NONE;
        unique case (state_reg)
            ST_IDLE:
                cmd.load_item = in_valid;
            ST_PRECHK:
            begin
                if (sts.act == ACT_CLEAR)
                begin
                    cmd.clear_cnt = 1'b1;
                    cmd.set_ok    = 1'b1;
                end
                cmd.idx_zero = 1'b1;
            end
            ST_READ:
                cmd.rd = RD_SCAN;
            ST_CHECK:
            begin
                if (sts.match)
                begin
                    case (sts.act)
                        ACT_LOOKUP:
                        begin
                            cmd.set_hit = 1'b1;
                            cmd.set_ok  = 1'b1;
                        end
                        ACT_UNMAP:
                            cmd.set_ok = 1'b1;
                        ACT_PROTECT:
                        begin
                            cmd.wr     = WR_UPD;
                            cmd.set_ok = 1'b1;
                        end
                        ACT_UNMAP_RG:
                        begin
                            if (sts.cut == CUT_FULL)
                                cmd.set_ok = 1'b1;
                            else if (sts.cut != CUT_SPLIT || !sts.full)
                            begin
                                cmd.wr     = WR_UPD;
                                cmd.set_ok = 1'b1;
                            end
                        end
                        default:
                            cmd.set_ok = 1'b0;
                    endcase
                end
                else if (!sts.last)
                    cmd.idx_inc = 1'b1;
            end
            ST_REMOVE_RD:
                cmd.rd = RD_LAST;
            ST_REMOVE_WR:
            begin
                cmd.wr      = WR_MOVE;
                cmd.cnt_dec = 1'b1;
            end
            ST_SPLIT_WR:
            begin
                cmd.wr      = WR_SPLIT;
                cmd.cnt_inc = 1'b1;
            end
            ST_APPEND:
            begin
                cmd.wr      = WR_APPEND;
                cmd.cnt_inc = 1'b1;
                cmd.set_ok  = 1'b1;
            end
            ST_DONE:
                cmd.res_load = sts.out_free;
            default:
                cmd.load_item = 1'b0;
        endcase
    end

endmodule

// ===== sv/armt_dp.sv =====
module armt_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [armt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [armt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [armt_pkg::ACT_W-1:0]         action,
    input  logic [armt_pkg::ADDR_BITS-1:0]     virt_addr,
    input  logic [armt_pkg::ADDR_BITS-1:0]     phys_addr,
    input  logic [armt_pkg::ADDR_BITS-1:0]     length,
    input  logic [armt_pkg::RIGHTS_W-1:0]      rights,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic                               status,
    output logic                               hit,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_virt,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_phys,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_length,
    output logic [armt_pkg::RIGHTS_W-1:0]      found_rights,
    output logic [armt_pkg::CNT_W-1:0]         count,
    input  armt_pkg::cmd_t                     cmd,
    output armt_pkg::sts_t                     sts
);
    import armt_pkg::*;

    localparam int AW = ADDR_BITS;

    logic [SHIFT_W-1:0] page_shift_reg;
    logic [AW-1:0]      user_min_reg;
    logic [AW-1:0]      user_max_reg;
    logic [AW-1:0]      kernel_base_reg;

    act_t               act_reg;
    logic [AW-1:0]      v_reg;
    logic [AW-1:0]      p_reg;
    logic [AW-1:0]      len_reg;
    logic [RIGHTS_W-1:0] r_reg;

    logic [CNT_W-1:0]   cnt_reg;
    logic [IDX_W-1:0]   idx_reg;
    entry_t             mem [MAX_REGIONS];
    entry_t             rd_data_reg;

    logic               ok_reg;
    logic               hit_reg;
    entry_t             found_reg;

    logic               out_valid_reg;
    logic               status_reg;
    logic               hit_out_reg;
    entry_t             out_entry_reg;
    logic [CNT_W-1:0]   count_out_reg;

    // item checks
    logic [AW:0]   v_sum;
    logic [AW:0]   p_sum;
    logic [AW-1:0] v_end;
    logic [AW-1:0] pmask;
    logic          len_nz;
    logic          full;
    logic          raw_ok;
    logic          chk_ok;
    logic          win_user;
    logic          pre_ok;

    // entry checks
    entry_t        e;
    logic [AW:0]   e_sum;
    logic [AW:0]   ep_sum;
    logic [AW-1:0] e_end;
    logic          overlap;
    logic          contain;
    logic          exact;
    logic          cut_hit;
    logic          match;
    cut_t          cut;
    entry_t        hd_entry;
    entry_t        upd_entry;
    entry_t        wr_entry;
    logic [IDX_W-1:0] wr_addr;
    logic [IDX_W-1:0] rd_addr;
    logic          out_free;

    assign v_sum  = {1'b0, v_reg} + {1'b0, len_reg};
    assign p_sum  = {1'b0, p_reg} + {1'b0, len_reg};
    assign v_end  = v_sum[AW-1:0];
    assign pmask  = (AW'(1) << page_shift_reg) - AW'(1);
    assign len_nz = (len_reg != '0);
    assign full   = (cnt_reg >= CNT_W'(MAX_REGIONS));
    assign raw_ok = len_nz && !full && !v_sum[AW] && !p_sum[AW];
    assign chk_ok = (r_reg != '0) && !(r_reg[1] && r_reg[2])
                 && ((v_reg & pmask) == '0) && ((p_reg & pmask) == '0)
                 && ((len_reg & pmask) == '0);
    assign win_user = (v_reg >= user_min_reg)
                   && (v_sum <= ({1'b0, user_max_reg} + (AW+1)'(1)));

    always_comb
    begin
        unique case (act_reg)
            ACT_CLEAR:    pre_ok = 1'b1;
            ACT_RAW_MAP:  pre_ok = raw_ok;
            ACT_USER_MAP: pre_ok = raw_ok && chk_ok && win_user;
            ACT_KERN_MAP: pre_ok = raw_ok && chk_ok && (v_reg >= kernel_base_reg);
            ACT_UNMAP_RG: pre_ok = len_nz && !v_sum[AW];
            ACT_LOOKUP:   pre_ok = 1'b1;
            default:      pre_ok = len_nz;
        endcase
    end

    assign e      = rd_data_reg;
    assign e_sum  = {1'b0, e.virt} + {1'b0, e.len};
    assign ep_sum = {1'b0, e.phys} + {1'b0, e.len};
    assign e_end  = e_sum[AW-1:0];

    assign overlap = (e.len != '0) && (e_sum[AW] || ((v_reg < e_end) && (e.virt < v_end)));
    assign contain = (e.len != '0) && !e_sum[AW] && !ep_sum[AW]
                  && (v_reg >= e.virt) && (v_reg < e_end);
    assign exact   = (e.virt == v_reg) && (e.len == len_reg);
    // start of the region compares against the wrapped end
    assign cut_hit = (v_reg < e_end) && (e.virt < v_end);

    always_comb
    begin
        unique case (act_reg)
            ACT_UNMAP,
            ACT_PROTECT:  match = exact;
            ACT_UNMAP_RG: match = cut_hit;
            ACT_LOOKUP:   match = contain;
            ACT_CLEAR:    match = 1'b0;
            default:      match = overlap;
        endcase
    end

    always_comb
    begin
        if (v_reg <= e.virt)
            cut = (v_end >= e_end) ? CUT_FULL : CUT_HEAD;
        else
            cut = (v_end >= e_end) ? CUT_TAIL : CUT_SPLIT;
    end

    // upper piece left over above the cut
    always_comb
    begin
        hd_entry.virt   = v_end;
        hd_entry.phys   = e.phys + (v_end - e.virt);
        hd_entry.len    = e_end - v_end;
        hd_entry.rights = e.rights;
    end

    always_comb
    begin
        upd_entry = e;
        if (act_reg == ACT_PROTECT)
            upd_entry.rights = r_reg;
        else if (cut == CUT_HEAD)
            upd_entry = hd_entry;
        else
            upd_entry.len = v_reg - e.virt;
    end

    always_comb
    begin
        wr_entry = e;
        wr_addr  = idx_reg;
        case (cmd.wr)
            WR_UPD:
                wr_entry = upd_entry;
            WR_SPLIT:
            begin
                wr_entry = hd_entry;
                wr_addr  = cnt_reg[IDX_W-1:0];
            end
            WR_APPEND:
            begin
                wr_entry.virt   = v_reg;
                wr_entry.phys   = p_reg;
                wr_entry.len    = len_reg;
                wr_entry.rights = r_reg;
                wr_addr         = cnt_reg[IDX_W-1:0];
            end
            default:
                wr_entry = e;
        endcase
    end

    assign rd_addr = (cmd.rd == RD_LAST) ? IDX_W'(cnt_reg - CNT_W'(1)) : idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr != WR_NONE)
            mem[wr_addr] <= wr_entry;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd != RD_NONE)
            rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_shift_reg  <= PAGE_SHIFT_RST;
            user_min_reg    <= USER_MIN_RST;
            user_max_reg    <= USER_MAX_RST;
            kernel_base_reg <= KERNEL_BASE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PAGE_SHIFT:  page_shift_reg  <= cfg_data[SHIFT_W-1:0];
                CFG_USER_MIN:    user_min_reg    <= AW'(cfg_data);
                CFG_USER_MAX:    user_max_reg    <= AW'(cfg_data);
                CFG_KERNEL_BASE: kernel_base_reg <= AW'(cfg_data);
                default:         page_shift_reg  <= page_shift_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg <= act_t'(action);
            v_reg   <= virt_addr;
            p_reg   <= phys_addr;
            len_reg <= length;
            r_reg   <= rights;
        end
        if (cmd.load_item)
            found_reg <= '0;
        else if (cmd.set_hit)
            found_reg <= e;
        if (cmd.idx_zero)
            idx_reg <= '0;
        else if (cmd.idx_inc)
            idx_reg <= idx_reg + IDX_W'(1);
        if (cmd.res_load)
        begin
            status_reg    <= !ok_reg;
            hit_out_reg   <= hit_reg;
            out_entry_reg <= found_reg;
            count_out_reg <= cnt_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ok_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_cnt)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + CNT_W'(1);
            else if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - CNT_W'(1);
            if (cmd.load_item)
            begin
                ok_reg  <= 1'b0;
                hit_reg <= 1'b0;
            end
            else
            begin
                if (cmd.set_ok)
                    ok_reg <= 1'b1;
                if (cmd.set_hit)
                    hit_reg <= 1'b1;
            end
            if (cmd.res_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_free = !out_valid_reg || !out_stall;

    assign sts.act      = act_reg;
    assign sts.pre_ok   = pre_ok;
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.full     = full;
    assign sts.last     = ((CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg);
    assign sts.match    = match;
    assign sts.cut      = cut;
    assign sts.out_free = out_free;

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_out_reg;
    assign found_virt   = out_entry_reg.virt;
    assign found_phys   = out_entry_reg.phys;
    assign found_length = out_entry_reg.len;
    assign found_rights = out_entry_reg.rights;
    assign count        = count_out_reg;

endmodule

// ===== sv/address_region_map_table_unit.sv =====
// Region map table with up to 16 entries held in a single-port table memory.
// Each word is one operation and gives exactly one result word. An item walks
// the table one entry at a time in two steps (read, then check) until a hit,
// a conflict or the end, and then writes back where the action needs it.
// Only one word is in flight; a new word is taken while a finished result
// still waits on the output register. Clear empties the table at once; unmap
// and range unmap keep the table packed by moving the last entry into any
// hole. Configuration must be written only while the unit is idle.
module address_region_map_table_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [armt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [armt_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [armt_pkg::ACT_W-1:0]         action,
    input  logic [armt_pkg::ADDR_BITS-1:0]     virt_addr,
    input  logic [armt_pkg::ADDR_BITS-1:0]     phys_addr,
    input  logic [armt_pkg::ADDR_BITS-1:0]     length,
    input  logic [armt_pkg::RIGHTS_W-1:0]      rights,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               status,
    output logic                               hit,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_virt,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_phys,
    output logic [armt_pkg::ADDR_BITS-1:0]     found_length,
    output logic [armt_pkg::RIGHTS_W-1:0]      found_rights,
    output logic [armt_pkg::CNT_W-1:0]         count
);
    import armt_pkg::*;

    cmd_t   cmd;
    sts_t   sts;
    state_t state;

    armt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd),
        .state    (state)
    );

    armt_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .virt_addr    (virt_addr),
        .phys_addr    (phys_addr),
        .length       (length),
        .rights       (rights),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .status       (status),
        .hit          (hit),
        .found_virt   (found_virt),
        .found_phys   (found_phys),
        .found_length (found_length),
        .found_rights (found_rights),
        .count        (count),
        .cmd          (cmd),
        .sts          (sts)
    );

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CNT_W'(MAX_REGIONS)))
        else $error("region count above table size");

    a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (in_stall && state == ST_PRECHK))
        else $error("word accepted without starting work");

    a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && hit) |-> (!status && found_length != '0))
        else $error("hit reported with bad status or empty region");

    a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state == ST_DONE && (!out_valid || !out_stall)) |=> (out_valid && !in_stall))
        else $error("finished word not delivered");

endmodule
